>>> hdl/scd_pkg.sv
package scd_pkg;

    localparam int CORE_COUNT = 8;
    localparam int DIR_SETS  = 64;
    localparam int DIR_WAYS  = 4;
    localparam int SET_W     = $clog2(DIR_SETS);
    localparam int WAY_W     = (DIR_WAYS > 1) ? $clog2(DIR_WAYS) : 1;
    localparam int TAG_W     = 40;
    localparam int ADDR_W    = 48;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_EXCL  = 2'd1;
    localparam logic [1:0] OP_EVICT = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [0:0] REG_ATTACHED   = 1'b0;
    localparam logic [0:0] REG_LINE_SHIFT = 1'b1;

    localparam logic [7:0] CORE_MASK = (CORE_COUNT >= 8) ? 8'hFF
                                     : 8'((1 << CORE_COUNT) - 1);

    typedef struct packed {
        logic [1:0]        op;
        logic [2:0]        core;
        logic [ADDR_W-1:0] address;
        logic [7:0]        present_mask;
        logic [7:0]        dirty_mask;
    } req_t;

    typedef struct packed {
        logic       found;
        logic       dirty_seen;
        logic [2:0] source_core;
        logic [7:0] writeback_mask;
        logic [7:0] invalidate_mask;
        logic [3:0] sharer_count;
        logic       false_sharing;
        logic       owner_valid;
        logic [2:0] owner_core;
        logic       dir_full;
    } rsp_t;

    // one directory way as stored
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [7:0]       sharers;
        logic             owned;
        logic [2:0]       owner;
    } way_t;

endpackage

>>> hdl/scd_way_ram.sv
// One directory way: synchronous RAM, one read and one write port
module scd_way_ram (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [scd_pkg::SET_W-1:0] wr_addr,
    input  scd_pkg::way_t             wr_data,
    input  logic [scd_pkg::SET_W-1:0] rd_addr,
    output scd_pkg::way_t             rd_data
);
    scd_pkg::way_t mem [scd_pkg::DIR_SETS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> hdl/snoop_coherence_directory_core.sv
// Timing: the set is read at the accepting edge, compared and written back in
// the next cycle, and the result is registered at the end of that cycle.
// Intake: a new request is not taken while the last one is being compared
// and written back (set read, then compare and write back); intake also
// stalls while the output register is full and stalled.
// Reset: valid bits (flip-flops) cleared at once, attached_mask 0,
// line_shift 6; no memory clearing pass.
module snoop_coherence_directory_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  scd_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output scd_pkg::rsp_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [0:0]    cfg_index,
    input  logic [7:0]    cfg_data
);
    localparam int SW = scd_pkg::SET_W;
    localparam int WW = scd_pkg::WAY_W;

    // configuration
    logic [7:0] attached_reg;
    logic [3:0] shift_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attached_reg <= '0;
            shift_reg    <= 4'd6;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                scd_pkg::REG_ATTACHED:   attached_reg <= cfg_data;
                scd_pkg::REG_LINE_SHIFT: shift_reg    <= cfg_data[3:0];
                default:                 attached_reg <= attached_reg;
            endcase
        end
    end

    // request stage: key computed at intake
    logic                     busy_reg;
    scd_pkg::req_t            req_reg;
    logic [SW-1:0]            set_reg;
    logic [scd_pkg::TAG_W-1:0] tag_reg;
    logic [3:0]               sh;
    logic [scd_pkg::ADDR_W-1:0] line;
    logic                     accept;
    logic                     out_full_reg;

    assign sh     = (shift_reg < 4'd2) ? 4'd2 : ((shift_reg > 4'd12) ? 4'd12 : shift_reg);
    assign line   = in_data.address >> sh;
    assign in_stall = busy_reg || (out_full_reg && out_stall);
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
        end
    end

    // way memories and valid bits
    scd_pkg::way_t rd_way [scd_pkg::DIR_WAYS];
    scd_pkg::way_t wr_way;
    logic [scd_pkg::DIR_WAYS-1:0] wr_en;
    logic [SW-1:0] rd_set;
    logic [scd_pkg::DIR_WAYS-1:0] valid_reg [scd_pkg::DIR_SETS];
    logic [scd_pkg::DIR_WAYS-1:0] valid_next;
    logic [scd_pkg::DIR_WAYS-1:0] vld_reg;

    assign rd_set = line[SW-1:0];

    // valid bits of the set are read at intake, next to the way memories
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
            set_reg <= line[SW-1:0];
            tag_reg <= scd_pkg::TAG_W'(line >> SW);
            vld_reg <= valid_reg[rd_set];
        end
    end

    for (genvar w = 0; w < scd_pkg::DIR_WAYS; w++)
    begin : g_way
        scd_way_ram u_ram (
            .clk     (clk),
            .wr_en   (wr_en[w]),
            .wr_addr (set_reg),
            .wr_data (wr_way),
            .rd_addr (rd_set),
            .rd_data (rd_way[w])
        );
    end

    // lookup, update, respond
    logic [1:0]    op;
    logic [7:0]    req_bit, others, dirt;
    logic [scd_pkg::DIR_WAYS-1:0] vld;
    logic          hit, has_free, use_entry, full;
    logic [WW-1:0] hit_way, free_way, sel_way;
    scd_pkg::way_t cur;
    scd_pkg::rsp_t rsp;
    logic [2:0]    src;
    logic [3:0]    cnt;

    always_comb
    begin
        op = (32'(req_reg.core) >= scd_pkg::CORE_COUNT) ? scd_pkg::OP_QUERY : req_reg.op;
        req_bit = 8'(1) << req_reg.core;
        vld = vld_reg;
        hit = 1'b0;
        hit_way = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int w = scd_pkg::DIR_WAYS - 1; w >= 0; w--)
        begin
            if (vld[w] && rd_way[w].tag == tag_reg)
            begin
                hit = 1'b1;
                hit_way = WW'(w);
            end
            if (!vld[w])
            begin
                has_free = 1'b1;
                free_way = WW'(w);
            end
        end
        others = req_reg.present_mask & attached_reg & scd_pkg::CORE_MASK & ~req_bit;
        dirt = others & req_reg.dirty_mask;
        src = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (dirt[i])
            begin
                src = 3'(i);
            end
        end
        sel_way = hit ? hit_way : free_way;
        cur = rd_way[sel_way];
        if (!hit)
        begin
            cur.sharers = '0;
            cur.owned = 1'b0;
            cur.owner = '0;
            cur.tag = tag_reg;
        end
        wr_en = '0;
        valid_next = vld;
        full = 1'b0;
        use_entry = hit;
        rsp = '0;
        case (op)
            scd_pkg::OP_READ, scd_pkg::OP_EXCL:
            begin
                rsp.found = |others;
                rsp.dirty_seen = |dirt;
                rsp.source_core = src;
                if (op == scd_pkg::OP_READ)
                begin
                    rsp.writeback_mask = dirt;
                    cur.sharers = cur.sharers | others | req_bit;
                end
                else
                begin
                    rsp.invalidate_mask = others;
                    cur.sharers = '0;
                    cur.owned = 1'b1;
                    cur.owner = req_reg.core;
                end
                if (hit || has_free)
                begin
                    use_entry = 1'b1;
                    wr_en[sel_way] = busy_reg;
                    valid_next[sel_way] = 1'b1;
                end
                else
                begin
                    full = 1'b1;
                end
            end
            scd_pkg::OP_EVICT:
            begin
                if (hit)
                begin
                    cur.sharers = cur.sharers & ~req_bit;
                    if (cur.owned && cur.owner == req_reg.core)
                    begin
                        cur.owned = 1'b0;
                        cur.owner = '0;
                    end
                    wr_en[sel_way] = busy_reg;
                    if (cur.sharers == '0 && !cur.owned)
                    begin
                        valid_next[sel_way] = 1'b0;
                        use_entry = 1'b0;
                    end
                end
            end
            default:
            begin
                use_entry = hit;
            end
        endcase
        wr_way = cur;
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + 4'(cur.sharers[i]);
        end
        rsp.dir_full = full;
        if (use_entry)
        begin
            rsp.sharer_count = cnt;
            rsp.false_sharing = cnt > 4'd1;
            rsp.owner_valid = cur.owned;
            rsp.owner_core = cur.owned ? cur.owner : 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < scd_pkg::DIR_SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (busy_reg)
            begin
                valid_reg[set_reg] <= valid_next;
                out_full_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            out_data <= rsp;
        end
    end

    assign out_valid = out_full_reg;

    // checks
    a_no_full_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !(out_full_reg && out_stall))
        else $error("result overwritten while held");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_en))
        else $error("more than one way written");
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> !busy_reg)
        else $error("request stage held two cycles");
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && full) |-> (wr_en == '0))
        else $error("write on full set");
endmodule
